// ===== src/sfd_pkg.sv =====
// Shared types, byte codes and defaults for the SLIP frame decoder.
package sfd_pkg;

  localparam int unsigned BufferBytesDefault = 128;

  localparam logic [7:0] CodeEnd    = 8'hC0;
  localparam logic [7:0] CodeEsc    = 8'hDB;
  localparam logic [7:0] CodeEscEnd = 8'hDC;
  localparam logic [7:0] CodeEscEsc = 8'hDD;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindFrame  = 2'd1,
    KindOrphan = 2'd2
  } sfd_kind_e;

  typedef struct packed {
    sfd_kind_e  kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic       purged;
  } sfd_result_t;

  // Handshake between the decode stage and the output register.
  typedef struct packed {
    logic        valid;
    sfd_result_t result;
  } sfd_req_t;

endpackage

// ===== src/sfd_decode.sv =====
// Input register, escape/count state and per-byte decode logic.
module sfd_decode #(
  parameter int unsigned BufferBytes = sfd_pkg::BufferBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output sfd_pkg::sfd_req_t out_req_o,
  input  logic             out_ready_i
);

  localparam logic [7:0] WrapCount = 8'((BufferBytes - 2) % 256);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       esc_q, esc_d;
  logic [7:0] count_q, count_d;

  logic       is_end, is_esc, has_result, fire, wrap;
  logic [7:0] value, count_inc;
  sfd_pkg::sfd_result_t res;

  assign is_end     = (byte_q == sfd_pkg::CodeEnd);
  assign is_esc     = (byte_q == sfd_pkg::CodeEsc);
  assign has_result = !is_esc;
  assign fire       = valid_q && (!has_result || out_ready_i);
  assign in_ready_o = !valid_q || fire;
  assign count_inc  = count_q + 8'd1;
  assign wrap       = (count_inc == WrapCount);

  always_comb begin
    if (esc_q && byte_q == sfd_pkg::CodeEscEnd) begin
      value = sfd_pkg::CodeEnd;
    end else if (esc_q && byte_q == sfd_pkg::CodeEscEsc) begin
      value = sfd_pkg::CodeEsc;
    end else begin
      value = byte_q;
    end
  end

  always_comb begin
    esc_d      = esc_q;
    count_d    = count_q;
    res.kind   = sfd_pkg::KindData;
    res.data   = value;
    res.pos    = count_q;
    res.purged = 1'b0;
    if (is_end) begin
      res.data = 8'd0;
      if (count_q != 8'd0) begin
        res.kind = sfd_pkg::KindFrame;
        count_d  = 8'd0;
        esc_d    = 1'b0;
      end else begin
        res.kind = sfd_pkg::KindOrphan;
        res.pos  = 8'd0;
      end
    end else if (is_esc) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      if (wrap) begin
        count_d    = 8'd0;
        res.purged = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
  end

  assign out_req_o.valid  = valid_q && has_result;
  assign out_req_o.result = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      esc_q   <= 1'b0;
      count_q <= 8'd0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (fire) begin
        esc_q   <= esc_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  // Count never rests on the purge threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != WrapCount || WrapCount == 8'd0)
    else $error("byte count reached the purge threshold");

  // A completed frame leaves the count and escape flag cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.kind == sfd_pkg::KindFrame |=> count_q == 8'd0 && !esc_q)
    else $error("state not cleared after frame end");

  // An escape byte arms the flag and leaves the count alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_esc |=> esc_q && $stable(count_q))
    else $error("escape byte mishandled");

endmodule

// ===== src/sfd_out_reg.sv =====
// Result register toward the output stream.
module sfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::sfd_req_t    in_req_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfd_pkg::sfd_result_t out_result_o
);

  logic                 valid_q;
  sfd_pkg::sfd_result_t result_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_req_i.valid) begin
      result_q <= in_req_i.result;
    end
  end

endmodule

// ===== src/slip_frame_decoder_top.sv =====
// Top level of the SLIP frame decoder: byte stream in, decode events out.
//
// Each received byte enters on the slave stream and is held in an input
// register; combinational decode logic resolves the END/ESC codes and the
// frame byte count, and the event lands in a result register on the master
// stream. One byte is accepted every clock cycle while the master side takes
// results, so throughput is one byte per cycle; the only loop is the one-bit
// escape flag and the 8-bit frame counter, both updated as the decode stage
// hands its byte on. An ESC byte gives no event. END on a non-empty frame
// reports the frame length (kind 1), END on an empty frame reports an orphan
// (kind 2). A data byte that brings the count to BufferBytes - 2 is still
// delivered, flagged purged, and the frame is dropped with the count returned
// to zero.
module slip_frame_decoder_top #(
  parameter int unsigned BufferBytes = sfd_pkg::BufferBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] position, [16] purged
  output logic [1:0]  m_axis_tuser_o    // [1:0] event_kind
);

  sfd_pkg::sfd_req_t    dec_req;
  sfd_pkg::sfd_result_t out_result;
  logic                 out_reg_ready;

  // Decode stage: input register plus escape and count state.
  sfd_decode #(
    .BufferBytes(BufferBytes)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .out_req_o  (dec_req),
    .out_ready_i(out_reg_ready)
  );

  // Result register: hold the event while the master side stalls.
  sfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (dec_req),
    .in_ready_o  (out_reg_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_result_o(out_result)
  );

  // Pack the event fields, lowest bit first, zero filled to whole bytes.
  assign m_axis_tdata_o = {7'd0, out_result.purged, out_result.pos, out_result.data};
  assign m_axis_tuser_o = out_result.kind;

endmodule

// ===== dv/tb_slip_frame_decoder_top.sv =====
// Self-checking testbench for the SLIP frame decoder: directed table, then random frames.
module tb_slip_frame_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned BufLen         = BufferBytesDefault;
  localparam logic [7:0]  PurgeCount     = 8'(BufLen - 2);
  localparam int          ItemTarget     = 1250;
  localparam int          QuietTail      = 150;
  localparam int          LongHoldCycles = 400;
  localparam int          NumRows        = 23;

  // One directed request: the byte, whether its outcome is typed in here,
  // and if so whether it gives an event and which one.
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic        gives;
    sfd_result_t ev;
  } slip_row_t;

  localparam sfd_result_t NoEv = '0;

  localparam slip_row_t SlipRows [NumRows] = '{
    '{8'hC0, 1'b1, 1'b1, '{KindOrphan, 8'h00, 8'h00, 1'b0}},  // orphan END after reset
    '{8'h00, 1'b1, 1'b1, '{KindData,   8'h00, 8'h00, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{KindData,   8'hFF, 8'h01, 1'b0}},
    '{8'hDB, 1'b1, 1'b0, NoEv},                               // ESC gives nothing
    '{8'hDB, 1'b1, 1'b0, NoEv},                               // ESC while already armed
    '{8'hDC, 1'b1, 1'b1, '{KindData,   8'hC0, 8'h02, 1'b0}},
    '{8'hDB, 1'b1, 1'b0, NoEv},
    '{8'hDD, 1'b1, 1'b1, '{KindData,   8'hDB, 8'h03, 1'b0}},
    '{8'hDB, 1'b0, 1'b0, NoEv},                               // ESC then a plain byte
    '{8'h41, 1'b0, 1'b0, NoEv},
    '{8'hDC, 1'b0, 1'b0, NoEv},                               // ESC_END with no ESC
    '{8'hDD, 1'b0, 1'b0, NoEv},
    '{8'hC0, 1'b1, 1'b1, '{KindFrame,  8'h00, 8'h07, 1'b0}},
    '{8'hDB, 1'b0, 1'b0, NoEv},                               // armed across an orphan END
    '{8'hC0, 1'b1, 1'b1, '{KindOrphan, 8'h00, 8'h00, 1'b0}},
    '{8'hDC, 1'b0, 1'b0, NoEv},
    '{8'hDB, 1'b0, 1'b0, NoEv},                               // frame END clears the flag
    '{8'hC0, 1'b1, 1'b1, '{KindFrame,  8'h00, 8'h01, 1'b0}},
    '{8'hDC, 1'b0, 1'b0, NoEv},
    '{8'hC0, 1'b1, 1'b1, '{KindFrame,  8'h00, 8'h01, 1'b0}},
    '{8'h80, 1'b0, 1'b0, NoEv},
    '{8'h7F, 1'b0, 1'b0, NoEv},
    '{8'hC0, 1'b0, 1'b0, NoEv}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  // Decoder state as the predictor sees it.
  logic        esc_armed;
  logic [7:0]  frame_len;

  sfd_result_t pending_events [$];
  int          errors     = 0;
  int          items_sent = 0;
  bit          quiet      = 1'b0;   // no idling on either side in the tail
  bit          send_gaps  = 1'b1;
  bit          long_hold  = 1'b0;   // ask the receiver for one long hold-off

  slip_frame_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one byte into the event it causes; advance the frame state.
  function automatic bit slip_decode(input logic [7:0] rx, output sfd_result_t ev);
    ev = '0;
    if (rx == CodeEnd) begin
      if (frame_len != 8'd0) begin
        ev.kind   = KindFrame;
        ev.pos    = frame_len;
        frame_len = 8'd0;
        esc_armed = 1'b0;
      end else begin
        // Orphan END leaves the escape flag as it was.
        ev.kind = KindOrphan;
      end
      return 1'b1;
    end
    if (rx == CodeEsc) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    ev.kind = KindData;
    if (esc_armed && rx == CodeEscEnd) begin
      ev.data = CodeEnd;
    end else if (esc_armed && rx == CodeEscEsc) begin
      ev.data = CodeEsc;
    end else begin
      ev.data = rx;
    end
    esc_armed = 1'b0;
    ev.pos    = frame_len;
    frame_len = frame_len + 8'd1;
    // Buffer full: deliver the byte flagged, then drop the frame.
    if (frame_len == PurgeCount) begin
      frame_len = 8'd0;
      ev.purged = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Offer one request and hold it until accepted; log what it should cause.
  // Where the row types in an outcome, that outcome replaces the prediction.
  task automatic put_byte(input logic [7:0] rx, input bit typed, input bit gives,
                          input sfd_result_t typed_ev);
    sfd_result_t ev;
    bit          has;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    has = slip_decode(rx, ev);
    if (typed) begin
      has = gives;
      ev  = typed_ev;
    end
    if (has) pending_events.push_back(ev);
    items_sent++;
    if (!quiet && send_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic put_raw(input logic [7:0] rx);
    put_byte(rx, 1'b0, 1'b0, NoEv);
  endtask

  // Send one payload byte with proper escaping.
  task automatic put_payload(input logic [7:0] v);
    if (v == CodeEnd) begin
      put_raw(CodeEsc);
      put_raw(CodeEscEnd);
    end else if (v == CodeEsc) begin
      put_raw(CodeEsc);
      put_raw(CodeEscEsc);
    end else begin
      put_raw(v);
    end
  endtask

  // Bias toward the extremes and the framing codes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CodeEnd;
      3:       return CodeEsc;
      4:       return CodeEscEnd;
      5:       return CodeEscEsc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus: reset, directed table, then random frames.
  initial begin
    int          frame_no;
    int          len;
    logic [7:0]  v;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    esc_armed = 1'b0;
    frame_len = 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SlipRows[i]) begin
      put_byte(SlipRows[i].rx, SlipRows[i].typed, SlipRows[i].gives, SlipRows[i].ev);
    end

    frame_no = 0;
    while (items_sent < ItemTarget) begin
      quiet     = (items_sent > ItemTarget - QuietTail);
      send_gaps = ($urandom_range(0, 3) != 0);
      frame_no++;
      // Hold the receiver off once while requests keep coming.
      if (frame_no == 5) long_hold = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          // Noise: raw bytes of any value.
          repeat ($urandom_range(1, 8)) put_raw(pick_byte());
        end
        1: begin
          // Broken frame: up to five random bytes, then a dangling ESC, sometimes followed by END.
          repeat ($urandom_range(0, 5)) put_raw(8'($urandom_range(0, 255)));
          put_raw(CodeEsc);
          if ($urandom_range(0, 1) == 0) put_raw(CodeEnd);
        end
        default: begin
          // Well-formed frame; every so often long enough to fill the buffer.
          len = (frame_no % 25 == 1) ? $urandom_range(BufLen - 4, BufLen + 4)
                                     : $urandom_range(0, 16);
          for (int k = 0; k < len; k++) begin
            v = pick_byte();
            // Now and then an ESC before a byte that is no escape code.
            if ($urandom_range(0, 11) == 0 && v != CodeEnd && v != CodeEsc) begin
              put_raw(CodeEsc);
            end
            put_payload(v);
          end
          put_raw(CodeEnd);
        end
      endcase
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stall bursts, stretches without stalls, one long hold-off.
  initial begin
    bit stall_mode;
    stall_mode = 1'b1;
    m_axis_tready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && stall_mode && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
    end
  end

  // Compare each accepted event with the oldest one outstanding.
  always @(posedge clk_i) begin
    sfd_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t ns: event with none outstanding: kind %0d data 0x%0h pos %0d",
                 $time, m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[15:8]);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser_o !== want.kind)
          report_mismatch("event_kind", m_axis_tuser_o, want.kind);
        if (m_axis_tdata_o[7:0] !== want.data)
          report_mismatch("data_byte", m_axis_tdata_o[7:0], want.data);
        if (m_axis_tdata_o[15:8] !== want.pos)
          report_mismatch("position", m_axis_tdata_o[15:8], want.pos);
        if (m_axis_tdata_o[16] !== want.purged)
          report_mismatch("purged", m_axis_tdata_o[16], want.purged);
      end
    end
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/sfd_pkg.sv
src/sfd_decode.sv
src/sfd_out_reg.sv
src/slip_frame_decoder_top.sv
dv/tb_slip_frame_decoder_top.sv
